// File: design/bact_pkg.sv
// Shared types and constants for the bounded accumulator crossing-time block.
// No dependencies; imported by every module of the block.
package bact_pkg;

   localparam int MAX_STEPS  = 4096;
   localparam int STEP_W     = $clog2(MAX_STEPS);
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int CTIME_W    = STEP_W + FRAC_W + 1;
   localparam int DIV_W      = DATA_W + 4;
   localparam int DIV_STEPS  = FRAC_W + 1;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 3;

   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEPS - 1);

   // register index, taken from the word-address bit of paddr
   localparam logic CSR_IDX_LOWER_FLOOR = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_PREP,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } bact_state_type;

   typedef struct packed {
      logic load_in;
      logic do_sum;
      logic do_prep;
      logic do_setup;
      logic do_div;
      logic div_first;
      logic load_out;
   } bact_cmd_type;

   typedef struct packed {
      logic crossed;
      logic trivial;
   } bact_status_type;

endpackage

// File: design/bounded_accumulator_crossing_time.sv
// Top level: bounded accumulator with interpolated crossing time, CSR port.
// Depends on bact_pkg, bact_ctrl and bact_datapath.
// Flow: capture in IDLE, then SUM and PREP; without a crossing PREP goes to DONE.
// On a crossing SETUP follows, and unless the fraction is trivially 0 the 17-step
// restoring divider (DIV) computes the interpolated fraction before DONE, which
// waits until the output register is free; one transaction is in flight at a time.
// Reset (synchronous, active high) clears the trial state, the FSM and lower_floor.
module bounded_accumulator_crossing_time import bact_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_sample_missing,
   input  logic signed [DATA_W-1:0] req_upper_bound,
   input  logic                     req_trial_start,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_running_sum,
   output logic                     rsp_sum_valid,
   output logic                     rsp_crossed,
   output logic [CTIME_W-1:0]       rsp_crossing_time,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]        pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   bact_cmd_type             cmd;
   bact_status_type          status;
   logic signed [DATA_W-1:0] lower_floor_ff, lower_floor_in;
   logic                     csr_write;

   // Single register at word 0; paddr[2] selects the word, byte bits ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      lower_floor_in = lower_floor_ff;
      if (csr_write && (paddr[2] == CSR_IDX_LOWER_FLOOR)) begin
         lower_floor_in = pwdata;
      end
      prdata = (paddr[2] == CSR_IDX_LOWER_FLOOR) ? lower_floor_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_floor_ff <= '0;
      end else begin
         lower_floor_ff <= lower_floor_in;
      end
   end

   // FSM: one transaction at a time; the output register lets a new
   // transaction be taken while the previous result still waits.
   bact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // accumulate, floor, crossing test, interpolation divide
   bact_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .lower_floor        (lower_floor_ff),
      .req_sample         (req_sample),
      .req_sample_missing (req_sample_missing),
      .req_upper_bound    (req_upper_bound),
      .req_trial_start    (req_trial_start),
      .rsp_running_sum    (rsp_running_sum),
      .rsp_sum_valid      (rsp_sum_valid),
      .rsp_crossed        (rsp_crossed),
      .rsp_crossing_time  (rsp_crossing_time)
   );

endmodule

// File: design/bact_datapath.sv
// Datapath: input capture, accumulator state, interpolation operands,
// restoring divider for the crossing fraction and the result register. Uses bact_pkg.
module bact_datapath import bact_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  bact_cmd_type             cmd,
   output bact_status_type          status,
   input  logic signed [DATA_W-1:0] lower_floor,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_sample_missing,
   input  logic signed [DATA_W-1:0] req_upper_bound,
   input  logic                     req_trial_start,
   output logic signed [DATA_W-1:0] rsp_running_sum,
   output logic                     rsp_sum_valid,
   output logic                     rsp_crossed,
   output logic [CTIME_W-1:0]       rsp_crossing_time
);

   // captured transaction
   logic signed [DATA_W-1:0] elem_ff, bound_ff;
   logic                     start_ff;

   // trial state
   logic signed [DATA_W-1:0] acc_ff, prev_bound_ff;
   logic                     reached_ff;
   logic [STEP_W-1:0]        step_ff;

   // per-item working registers
   logic signed [DATA_W-1:0] res_sum_ff, prevb_ff;
   logic                     res_valid_ff, res_cross_ff;
   logic [STEP_W-1:0]        idx_ff;
   logic signed [DIV_W-1:0]  num_ff, den_ff;
   logic [DIV_W-1:0]         rem_ff, dvs_ff;
   logic [DIV_STEPS-1:0]     quo_ff;

   // output register
   logic signed [DATA_W-1:0] out_sum_ff;
   logic                     out_valid_ff, out_cross_ff;
   logic [CTIME_W-1:0]       out_ctime_ff;

   // sum stage
   logic [STEP_W-1:0]        idx;
   logic                     first, active, hit;
   logic signed [DATA_W-1:0] prevb, sat, floored;
   logic signed [DATA_W:0]   sum_wide;
   logic [STEP_W-1:0]        step_next;

   // interpolation and divider
   logic signed [DIV_W-1:0]  prevb_x, elem_x, sum_x, bound_x;
   logic [DIV_W-1:0]         trial;
   logic                     ge;
   logic [DIV_STEPS-1:0]     frac;
   logic [CTIME_W-1:0]       ctime;

   always_comb begin
      idx      = start_ff ? '0 : step_ff;
      first    = (idx == '0);
      prevb    = first ? bound_ff : prev_bound_ff;
      active   = start_ff || !reached_ff;
      sum_wide = (first ? '0 : {acc_ff[DATA_W-1], acc_ff}) + {elem_ff[DATA_W-1], elem_ff};
      // saturate when the carry out disagrees with the sign
      if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
         sat = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat = sum_wide[DATA_W-1:0];
      end
      floored   = (sat < lower_floor) ? lower_floor : sat;
      hit       = (floored >= bound_ff);
      step_next = (idx == STEP_MAX) ? idx : idx + 1'b1;
   end

   always_comb begin
      prevb_x = {{(DIV_W-DATA_W){prevb_ff[DATA_W-1]}}, prevb_ff};
      elem_x  = {{(DIV_W-DATA_W){elem_ff[DATA_W-1]}}, elem_ff};
      sum_x   = {{(DIV_W-DATA_W){res_sum_ff[DATA_W-1]}}, res_sum_ff};
      bound_x = {{(DIV_W-DATA_W){bound_ff[DATA_W-1]}}, bound_ff};
   end

   // num = Bprev - (sum - elem), den = num + sum - bound = Bprev + elem - bound
   always_comb begin
      status.crossed = res_cross_ff;
      status.trivial = (num_ff == '0) || (den_ff == '0) ||
                       (num_ff[DIV_W-1] != den_ff[DIV_W-1]);
      trial = cmd.div_first ? rem_ff : {rem_ff[DIV_W-2:0], 1'b0};
      ge    = (trial >= dvs_ff);
      // integer quotient bit set means the ratio is at least one: clamp
      frac  = quo_ff[DIV_STEPS-1] ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, quo_ff[FRAC_W-1:0]};
      ctime = {1'b0, idx_ff, {FRAC_W{1'b0}}} + CTIME_W'(frac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         prev_bound_ff <= '0;
         reached_ff    <= 1'b0;
         step_ff       <= '0;
         start_ff      <= 1'b0;
         res_cross_ff  <= 1'b0;
      end else begin
         if (cmd.load_in) begin
            start_ff <= req_trial_start;
         end
         if (cmd.do_sum) begin
            if (active) begin
               acc_ff <= floored;
            end
            reached_ff    <= active ? hit : 1'b1;
            prev_bound_ff <= bound_ff;
            step_ff       <= step_next;
            res_cross_ff  <= active && hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         elem_ff  <= req_sample_missing ? '0 : req_sample;
         bound_ff <= req_upper_bound;
      end
      if (cmd.do_sum) begin
         res_sum_ff   <= active ? floored : '0;
         res_valid_ff <= active;
         idx_ff       <= idx;
         prevb_ff     <= prevb;
      end
      if (cmd.do_prep) begin
         num_ff <= prevb_x + elem_x - sum_x;
         den_ff <= prevb_x + elem_x - bound_x;
      end
      if (cmd.do_setup) begin
         rem_ff <= num_ff[DIV_W-1] ? DIV_W'(-num_ff) : DIV_W'(num_ff);
         dvs_ff <= den_ff[DIV_W-1] ? DIV_W'(-den_ff) : DIV_W'(den_ff);
         quo_ff <= '0;
      end
      if (cmd.do_div) begin
         rem_ff <= ge ? trial - dvs_ff : trial;
         quo_ff <= {quo_ff[DIV_STEPS-2:0], ge};
      end
      if (cmd.load_out) begin
         out_sum_ff   <= res_sum_ff;
         out_valid_ff <= res_valid_ff;
         out_cross_ff <= res_cross_ff;
         out_ctime_ff <= res_cross_ff ? ctime : '0;
      end
   end

   assign rsp_running_sum   = out_sum_ff;
   assign rsp_sum_valid     = out_valid_ff;
   assign rsp_crossed       = out_cross_ff;
   assign rsp_crossing_time = out_ctime_ff;

endmodule

// File: design/bact_ctrl.sv
// Controller FSM: sequences capture, sum, interpolation setup, divider
// iterations and the output register load. Uses bact_pkg.
module bact_ctrl import bact_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  bact_status_type status,
   output bact_cmd_type    cmd
);

   bact_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      slot_free  = !(rsp_valid_ff && rsp_stall);
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.do_sum = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.do_prep = 1'b1;
            state_in    = status.crossed ? ST_SETUP : ST_DONE;
         end
         ST_SETUP: begin
            cmd.do_setup = 1'b1;
            div_cnt_in   = '0;
            state_in     = status.trivial ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.do_div    = 1'b1;
            cmd.div_first = (div_cnt_ff == '0);
            div_cnt_in    = div_cnt_ff + 1'b1;
            if (div_cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SUM))
      else $error("accepted transaction did not enter the sum step");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider iteration count overran");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.do_sum, cmd.do_prep, cmd.do_setup, cmd.do_div,
                cmd.load_out}))
      else $error("more than one datapath command at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.load_out)
      else $error("pending result overwritten");

endmodule
